### hw/rtl/tlss_pkg.sv
// ----------------------------------------------------------------------------
// tlss_pkg - shared types of the load/store and stack unit
// Access kinds, the command passed from the front to the back, back states.
// ----------------------------------------------------------------------------
`default_nettype none

package tlss_pkg;

	// access kind codes as they arrive on the request tuser
	typedef enum logic [3:0] {
		KIND_LDR   = 4'd0,
		KIND_LDRB  = 4'd1,
		KIND_LDRH  = 4'd2,
		KIND_LDRSB = 4'd3,
		KIND_LDRSH = 4'd4,
		KIND_STR   = 4'd5,
		KIND_STRB  = 4'd6,
		KIND_STRH  = 4'd7,
		KIND_PUSH  = 4'd8,
		KIND_POP   = 4'd9
	} kind_t;

	// reset value of the window base register
	localparam logic [31:0] WINDOW_BASE_RESET = 32'h2000_0000;

	// bytes in one stack slot
	localparam int STACK_SLOT = 4;

	// control part of a queued command
	typedef struct packed {
		logic       rd;      // read bytes from ram
		logic       wr;      // write bytes to ram
		logic [2:0] nbytes;  // byte accesses to run, zero for none
		logic       sext;    // sign-extend a byte or halfword
		logic [3:0] dest;    // destination register of a pop
		logic       fault;   // access outside the window or stack
	} cmd_t;

	// back end sequencer states
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_ACCESS,
		BK_FIN
	} back_state_t;

endpackage

`default_nettype wire

### hw/rtl/tlss_ram.sv
// ----------------------------------------------------------------------------
// tlss_ram - generic single-port ram
// One access per cycle, write or read, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tlss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// storage array and registered read
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end
			rdata <= mem[addr];
		end
	end

endmodule

`default_nettype wire

### hw/rtl/tlss_front.sv
// ----------------------------------------------------------------------------
// tlss_front - request decode and stack pointer
// Forms the ram index, checks the window and stack limits, keeps the stack
// pointer and hands a command to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tlss_front #(
	parameter int RAM_SIZE = 256,
	parameter int AW       = $clog2(RAM_SIZE),
	parameter int SPW      = $clog2(RAM_SIZE + 1)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [31:0]          cfg_wdata,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [3:0]           kind,
	input  wire logic [31:0]          base,
	input  wire logic [31:0]          offset,
	input  wire logic [31:0]          store_data,
	input  wire logic [3:0]           reg_index,
	input  wire logic                 q_full,
	output logic                      q_push,
	output tlss_pkg::cmd_t            q_cmd,
	output logic      [AW-1:0]        q_addr,
	output logic      [31:0]          q_wdata,
	output logic      [SPW-1:0]       q_sp
);

	logic [31:0]    win_q;
	logic [SPW-1:0] sp_q;
	logic [SPW-1:0] sp_next;
	logic [31:0]    idx;
	logic [2:0]     size;
	logic           fits;

	// window base register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= tlss_pkg::WINDOW_BASE_RESET;
		end else if (cfg_we) begin
			win_q <= cfg_wdata;
		end
	end

	// ram index and access size
	assign idx  = base + offset - win_q;
	assign fits = idx <= (32'(RAM_SIZE) - 32'(size));

	always_comb begin
		unique case (tlss_pkg::kind_t'(kind)) inside
			tlss_pkg::KIND_LDR, tlss_pkg::KIND_STR:                        size = 3'd4;
			tlss_pkg::KIND_LDRH, tlss_pkg::KIND_LDRSH, tlss_pkg::KIND_STRH: size = 3'd2;
			tlss_pkg::KIND_LDRB, tlss_pkg::KIND_LDRSB, tlss_pkg::KIND_STRB: size = 3'd1;
			default:                                                        size = 3'd0;
		endcase
	end

	// command decode
	always_comb begin
		q_cmd   = '0;
		q_addr  = idx[AW-1:0];
		sp_next = sp_q;
		unique case (tlss_pkg::kind_t'(kind)) inside
			tlss_pkg::KIND_LDR, tlss_pkg::KIND_LDRB, tlss_pkg::KIND_LDRH,
			tlss_pkg::KIND_LDRSB, tlss_pkg::KIND_LDRSH: begin
				q_cmd.fault  = !fits;
				q_cmd.rd     = fits;
				q_cmd.nbytes = fits ? size : 3'd0;
				q_cmd.sext   = (tlss_pkg::kind_t'(kind) == tlss_pkg::KIND_LDRSB) ||
				               (tlss_pkg::kind_t'(kind) == tlss_pkg::KIND_LDRSH);
			end
			tlss_pkg::KIND_STR, tlss_pkg::KIND_STRB, tlss_pkg::KIND_STRH: begin
				q_cmd.fault  = !fits;
				q_cmd.wr     = fits;
				q_cmd.nbytes = fits ? size : 3'd0;
			end
			tlss_pkg::KIND_PUSH: begin
				if (sp_q < SPW'(tlss_pkg::STACK_SLOT)) begin
					q_cmd.fault = 1'b1;
				end else begin
					sp_next      = sp_q - SPW'(tlss_pkg::STACK_SLOT);
					q_cmd.wr     = 1'b1;
					q_cmd.nbytes = 3'(tlss_pkg::STACK_SLOT);
				end
				q_addr = sp_next[AW-1:0];
			end
			tlss_pkg::KIND_POP: begin
				q_cmd.dest = reg_index;
				if (sp_q > SPW'(RAM_SIZE - tlss_pkg::STACK_SLOT)) begin
					q_cmd.fault = 1'b1;
				end else begin
					sp_next      = sp_q + SPW'(tlss_pkg::STACK_SLOT);
					q_cmd.rd     = 1'b1;
					q_cmd.nbytes = 3'(tlss_pkg::STACK_SLOT);
				end
				q_addr = sp_q[AW-1:0];
			end
			default: begin
				q_cmd = '0;
			end
		endcase
	end

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;
	assign q_wdata  = store_data;
	assign q_sp     = sp_next;

	// stack pointer, moved as each request is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= SPW'(RAM_SIZE);
		end else if (q_push) begin
			sp_q <= sp_next;
		end
	end

	// stack pointer stays inside the ram
	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SPW'(RAM_SIZE))
		else $error("stack pointer above ram size");

endmodule

`default_nettype wire

### hw/rtl/tlss_queue.sv
// ----------------------------------------------------------------------------
// tlss_queue - command queue between front and back
// Small register fifo, one push and one pop per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tlss_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  valid
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full  = count_q == CW'(DEPTH);
	assign valid = count_q != '0;
	assign rdata = slot_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// no overflow and no underflow
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> valid)
		else $error("pop from empty queue");

endmodule

`default_nettype wire

### hw/rtl/tlss_back.sv
// ----------------------------------------------------------------------------
// tlss_back - access sequencer and result register
// Runs the byte accesses of one command on the ram, assembles and extends
// the loaded value and holds the result until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module tlss_back #(
	parameter int RAM_SIZE = 256,
	parameter int AW       = $clog2(RAM_SIZE),
	parameter int SPW      = $clog2(RAM_SIZE + 1)
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_valid,
	output logic                 q_pop,
	input  wire tlss_pkg::cmd_t  q_cmd,
	input  wire logic [AW-1:0]   q_addr,
	input  wire logic [31:0]     q_wdata,
	input  wire logic [SPW-1:0]  q_sp,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic      [31:0]     load_data,
	output logic      [3:0]      dest_reg,
	output logic                 fault,
	output logic      [SPW-1:0]  stack_offset
);

	tlss_pkg::back_state_t state_q;
	tlss_pkg::back_state_t state_next;
	tlss_pkg::cmd_t        cmd_q;
	logic [AW-1:0]         addr_q;
	logic [31:0]           wdata_q;
	logic [SPW-1:0]        sp_q;
	logic [1:0]            cnt_q;
	logic [31:0]           acc_q;
	logic                  rd_vld_q;
	logic [1:0]            rd_lane_q;
	logic                  out_vld_q;

	logic                  finish;
	logic                  take;
	logic                  ram_en;
	logic [AW-1:0]         ram_addr;
	logic [7:0]            ram_wdata;
	logic [7:0]            ram_rdata;
	logic [31:0]           merged;
	logic [31:0]           extended;

	// byte-wide ram
	tlss_ram #(
		.WIDTH(8),
		.DEPTH(RAM_SIZE)
	) u_ram (
		.clk  (clk),
		.en   (ram_en),
		.we   (cmd_q.wr),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	assign finish    = (state_q == tlss_pkg::BK_FIN) && (!out_vld_q || out_ready);
	assign take      = q_valid && ((state_q == tlss_pkg::BK_IDLE) || finish);
	assign q_pop     = take;
	assign ram_en    = state_q == tlss_pkg::BK_ACCESS;
	assign ram_addr  = addr_q + AW'(cnt_q);
	assign ram_wdata = wdata_q[{cnt_q, 3'b000} +: 8];

	// next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			tlss_pkg::BK_IDLE: begin
				if (take) begin
					state_next = (q_cmd.nbytes == 3'd0) ? tlss_pkg::BK_FIN : tlss_pkg::BK_ACCESS;
				end
			end
			tlss_pkg::BK_ACCESS: begin
				if ({1'b0, cnt_q} == cmd_q.nbytes - 3'd1) begin
					state_next = tlss_pkg::BK_FIN;
				end
			end
			tlss_pkg::BK_FIN: begin
				if (take) begin
					state_next = (q_cmd.nbytes == 3'd0) ? tlss_pkg::BK_FIN : tlss_pkg::BK_ACCESS;
				end else if (finish) begin
					state_next = tlss_pkg::BK_IDLE;
				end
			end
			default: begin
				state_next = tlss_pkg::BK_IDLE;
			end
		endcase
	end

	// last read byte merged in as it arrives
	always_comb begin
		merged = acc_q;
		if (rd_vld_q) begin
			merged[{rd_lane_q, 3'b000} +: 8] = ram_rdata;
		end
	end

	// zero or sign extension of the loaded value
	always_comb begin
		case (cmd_q.nbytes)
			3'd1:    extended = {{24{cmd_q.sext && merged[7]}}, merged[7:0]};
			3'd2:    extended = {{16{cmd_q.sext && merged[15]}}, merged[15:0]};
			default: extended = merged;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tlss_pkg::BK_IDLE;
			rd_vld_q  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q  <= state_next;
			rd_vld_q <= ram_en && cmd_q.rd;
			if (finish) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// command, byte counter and assembly registers
	always_ff @(posedge clk) begin
		rd_lane_q <= cnt_q;
		if (take) begin
			cmd_q   <= q_cmd;
			addr_q  <= q_addr;
			wdata_q <= q_wdata;
			sp_q    <= q_sp;
			cnt_q   <= '0;
			acc_q   <= '0;
		end else begin
			if (ram_en) begin
				cnt_q <= cnt_q + 2'd1;
			end
			if (rd_vld_q) begin
				acc_q <= merged;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (finish) begin
			load_data    <= cmd_q.rd ? extended : 32'd0;
			dest_reg     <= cmd_q.dest;
			fault        <= cmd_q.fault;
			stack_offset <= sp_q;
		end
	end

	assign out_valid = out_vld_q;

	// byte counter stays below the access size
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tlss_pkg::BK_ACCESS) |-> ({1'b0, cnt_q} < cmd_q.nbytes))
		else $error("byte counter past access size");

	// a faulted command never touches the ram
	a_fault_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		ram_en |-> !cmd_q.fault)
		else $error("ram access for a faulted command");

endmodule

`default_nettype wire

### hw/rtl/thumb_load_store_stack_unit.sv
// ----------------------------------------------------------------------------
// thumb_load_store_stack_unit - load/store and stack unit over a byte ram
// Loads, stores, push and pop of one register word on a ram window.
//
//   channel    dir   handshake          payload
//   s_*        in    s_tvalid/s_tready  s_tdata, s_tuser (access kind)
//   m_*        out   m_tvalid/m_tready  m_tdata, m_tuser (fault)
//   cfg_*      in    cfg_we             cfg_wdata (window base)
//
// A request is decoded as it is taken and queued; the sequencer then runs one
// ram access per byte on the single byte port of the ram, then a result step,
// and a fault or unused kind goes straight to the result step. Requests keep
// entering while the queue has room and a result waits in its output register.
// Reset leaves the stack empty at the top and the window base at 0x20000000;
// ram contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module thumb_load_store_stack_unit #(
	parameter int RAM_SIZE = 256,
	localparam int AW       = $clog2(RAM_SIZE),
	localparam int SPW      = $clog2(RAM_SIZE + 1),
	localparam int OUT_BITS = 36 + SPW,
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [31:0]       cfg_wdata,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	// base[31:0], offset[63:32], store_data[95:64], reg_index[99:96], zero pad
	input  wire logic [103:0]      s_tdata,
	// kind[3:0]
	input  wire logic [3:0]        s_tuser,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	// load_data[31:0], dest_reg[35:32], stack_offset[36 +: SPW], zero pad
	output logic      [OUT_W-1:0]  m_tdata,
	// fault[0]
	output logic      [0:0]        m_tuser
);

	localparam int QW = $bits(tlss_pkg::cmd_t) + AW + 32 + SPW;

	tlss_pkg::cmd_t f_cmd;
	tlss_pkg::cmd_t b_cmd;
	logic [AW-1:0]  f_addr;
	logic [AW-1:0]  b_addr;
	logic [31:0]    f_wdata;
	logic [31:0]    b_wdata;
	logic [SPW-1:0] f_sp;
	logic [SPW-1:0] b_sp;
	logic           q_push;
	logic           q_full;
	logic           q_pop;
	logic           q_valid;
	logic [QW-1:0]  q_rdata;
	logic [31:0]    load_data;
	logic [3:0]     dest_reg;
	logic           fault;
	logic [SPW-1:0] stack_offset;

	// request decode
	tlss_front #(
		.RAM_SIZE(RAM_SIZE),
		.AW      (AW),
		.SPW     (SPW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.kind      (s_tuser),
		.base      (s_tdata[31:0]),
		.offset    (s_tdata[63:32]),
		.store_data(s_tdata[95:64]),
		.reg_index (s_tdata[99:96]),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_cmd     (f_cmd),
		.q_addr    (f_addr),
		.q_wdata   (f_wdata),
		.q_sp      (f_sp)
	);

	// command queue
	tlss_queue #(
		.WIDTH(QW),
		.DEPTH(2)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata ({f_cmd, f_addr, f_wdata, f_sp}),
		.full  (q_full),
		.pop   (q_pop),
		.rdata (q_rdata),
		.valid (q_valid)
	);

	assign {b_cmd, b_addr, b_wdata, b_sp} = q_rdata;

	// access sequencer
	tlss_back #(
		.RAM_SIZE(RAM_SIZE),
		.AW      (AW),
		.SPW     (SPW)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_pop       (q_pop),
		.q_cmd       (b_cmd),
		.q_addr      (b_addr),
		.q_wdata     (b_wdata),
		.q_sp        (b_sp),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.load_data   (load_data),
		.dest_reg    (dest_reg),
		.fault       (fault),
		.stack_offset(stack_offset)
	);

	// result packing
	assign m_tdata    = OUT_W'({stack_offset, dest_reg, load_data});
	assign m_tuser[0] = fault;

endmodule

`default_nettype wire
